// ----- hdl/mfp_pkg.sv -----
// ----------------------------------------------------------------------------
// mfp_pkg: shared types and constants of the mesh frame parser
// Frame layout offsets, result kinds, status codes, register indexes and the
// entry that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mfp_pkg;

  // Frame layout, byte offsets from the start of the frame.
  localparam logic [15:0] HEADER_BYTES = 16'd30;
  localparam logic [15:0] NONCE_BYTES  = 16'd12;
  localparam logic [15:0] TAG_BYTES    = 16'd16;
  localparam logic [15:0] OFS_VERSION  = 16'd0;
  localparam logic [15:0] OFS_TYPE     = 16'd1;
  localparam logic [15:0] OFS_SENDER   = 16'd2;
  localparam logic [15:0] OFS_DEST     = 16'd6;
  localparam logic [15:0] OFS_MSGID    = 16'd10;
  localparam logic [15:0] OFS_TTL      = 16'd14;
  localparam logic [15:0] OFS_FLAGS    = 16'd15;
  localparam logic [15:0] OFS_NONCE    = 16'd16;
  localparam logic [15:0] OFS_LEN      = 16'd28;
  localparam logic [15:0] OFS_LEN_HI   = 16'd29;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  // Smallest legal frame with an empty payload, at 17 bits for length sums.
  localparam logic [16:0] HDR_TAG_BYTES = 17'({1'b0, HEADER_BYTES} + {1'b0, TAG_BYTES});
  localparam logic [16:0] TAG_BYTES_W   = 17'({1'b0, TAG_BYTES});

  // Result kinds.
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_NONCE   = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_TAG     = 3'd3;
  localparam logic [2:0] KIND_STATUS  = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_VERSION   = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  // Configuration register indexes.
  localparam logic [7:0] REG_EXPECTED_VERSION = 8'd0;
  localparam logic [7:0] REG_MAX_PAYLOAD      = 8'd1;

  localparam logic [7:0]  EXPECTED_VERSION_RST = 8'd1;
  localparam logic [15:0] MAX_PAYLOAD_RST      = 16'd200;

  // Packed width of the master tdata bus (146 field bits, padded to bytes).
  localparam int unsigned OUT_DATA_W = 152;

  // One classified input byte: an optional byte or header result, then an
  // optional status result.
  typedef struct packed {
    logic        has_res;
    logic [2:0]  kind;
    logic [7:0]  msg_type;
    logic [31:0] src_id;
    logic [31:0] dest_id;
    logic [31:0] msg_id;
    logic [7:0]  ttl;
    logic [7:0]  flags;
    logic [15:0] decl_len;
    logic [7:0]  byte_out;
    logic        has_stat;
    logic [1:0]  status;
  } mfp_entry_t;

endpackage

`default_nettype wire

// ----- hdl/mfp_front.sv -----
// ----------------------------------------------------------------------------
// mfp_front: byte counter, header capture and classification
// Captures header fields, tags each byte with its kind and computes the
// frame status on the final byte. Holds the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_front
  import mfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_fire,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_buffer,
  input  wire logic        cfg_fire,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             push,
  output mfp_entry_t       entry
);

  logic [15:0] byte_count;
  logic [7:0]  expected_version;
  logic [15:0] max_payload;
  logic [7:0]  first_byte;
  logic [7:0]  type_reg;
  logic [31:0] sender_reg;
  logic [31:0] dest_reg;
  logic [31:0] msgid_reg;
  logic [7:0]  ttl_reg;
  logic [7:0]  flags_reg;
  logic [15:0] length_reg;

  logic        sat;
  logic [1:0]  lane;
  logic [15:0] rel;
  logic [16:0] tag_end;
  logic [15:0] len_now;
  logic [15:0] length_now;
  logic [7:0]  first_now;
  logic [16:0] need_len;

  assign sat  = (byte_count == COUNT_MAX);
  // Offsets 2..13 map onto little-endian lanes 0..3 by the two low bits.
  assign lane = byte_count[1:0] - 2'd2;
  assign rel  = byte_count - HEADER_BYTES;
  assign tag_end = {1'b0, length_reg} + TAG_BYTES_W;

  always_comb begin
    len_now    = sat ? byte_count : byte_count + 16'd1;
    length_now = (!sat && byte_count == OFS_LEN_HI) ? {data_byte, length_reg[7:0]}
                                                    : length_reg;
    first_now  = (!sat && byte_count == OFS_VERSION) ? data_byte : first_byte;
    need_len   = {1'b0, length_now} + HDR_TAG_BYTES;
  end

  always_comb begin
    entry          = '0;
    entry.has_stat = end_of_buffer;
    if (!sat) begin
      if (byte_count >= OFS_NONCE && byte_count < OFS_LEN) begin
        entry.has_res  = 1'b1;
        entry.kind     = KIND_NONCE;
        entry.byte_out = data_byte;
      end else if (byte_count == OFS_LEN_HI) begin
        entry.has_res     = 1'b1;
        entry.kind        = KIND_HEADER;
        entry.msg_type    = type_reg;
        entry.src_id      = sender_reg;
        entry.dest_id     = dest_reg;
        entry.msg_id      = msgid_reg;
        entry.ttl         = ttl_reg;
        entry.flags       = flags_reg;
        entry.decl_len    = length_now;
      end else if (byte_count >= HEADER_BYTES) begin
        if (rel < length_reg) begin
          entry.has_res  = 1'b1;
          entry.kind     = KIND_PAYLOAD;
          entry.byte_out = data_byte;
        end else if ({1'b0, rel} < tag_end) begin
          entry.has_res  = 1'b1;
          entry.kind     = KIND_TAG;
          entry.byte_out = data_byte;
        end
      end
    end
    if (end_of_buffer) begin
      entry.kind = entry.has_res ? entry.kind : KIND_STATUS;
      if ({1'b0, len_now} < HDR_TAG_BYTES) begin
        entry.status = ST_SHORT;
      end else if (first_now != expected_version) begin
        entry.status = ST_VERSION;
      end else if (length_now > max_payload) begin
        entry.status = ST_TOO_LONG;
      end else if ({1'b0, len_now} < need_len) begin
        entry.status = ST_SHORT;
      end else begin
        entry.status = ST_OK;
      end
    end
  end

  assign push = in_fire && (entry.has_res || end_of_buffer);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      expected_version <= EXPECTED_VERSION_RST;
      max_payload      <= MAX_PAYLOAD_RST;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          REG_EXPECTED_VERSION: expected_version <= cfg_data[7:0];
          REG_MAX_PAYLOAD:      max_payload      <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        if (end_of_buffer) begin
          byte_count <= '0;
        end else if (!sat) begin
          byte_count <= byte_count + 16'd1;
        end
      end
    end
  end

  // Header capture. These registers are always written before they are read
  // within a frame, so they carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire && !sat) begin
      if (byte_count == OFS_VERSION) begin
        first_byte <= data_byte;
      end else if (byte_count == OFS_TYPE) begin
        type_reg <= data_byte;
      end else if (byte_count < OFS_DEST) begin
        sender_reg[lane*8 +: 8] <= data_byte;
      end else if (byte_count < OFS_MSGID) begin
        dest_reg[lane*8 +: 8] <= data_byte;
      end else if (byte_count < OFS_TTL) begin
        msgid_reg[lane*8 +: 8] <= data_byte;
      end else if (byte_count == OFS_TTL) begin
        ttl_reg <= data_byte;
      end else if (byte_count == OFS_FLAGS) begin
        flags_reg <= data_byte;
      end else if (byte_count == OFS_LEN) begin
        length_reg[7:0] <= data_byte;
      end else if (byte_count == OFS_LEN_HI) begin
        length_reg[15:8] <= data_byte;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mfp_fifo.sv -----
// ----------------------------------------------------------------------------
// mfp_fifo: short queue between front end and back end
// Register-based first-in first-out queue with a combinational head.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_fifo
  import mfp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
)(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire mfp_entry_t  din,
  input  wire logic        pop,
  output mfp_entry_t       dout,
  output logic             full,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mfp_entry_t    slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mfp_back.sv -----
// ----------------------------------------------------------------------------
// mfp_back: result sequencer and output register
// Unpacks each queued entry into one or two results on the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_back
  import mfp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mfp_entry_t            head,
  input  wire logic                  empty,
  output logic                       pop,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic [2:0]                 m_tuser,
  output logic                       m_tlast
);

  logic phase;   // set once the byte or header result of the head is out
  logic load;
  logic send_res;

  assign load     = !m_tvalid || m_tready;
  assign send_res = head.has_res && !phase;
  assign pop      = load && !empty && !(send_res && head.has_stat);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else if (load) begin
      m_tvalid <= !empty;
      if (!empty) begin
        phase <= send_res && head.has_stat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      if (send_res) begin
        m_tdata <= {6'd0, 2'd0, head.byte_out, head.decl_len, head.flags,
                    head.ttl, head.msg_id, head.dest_id, head.src_id,
                    head.msg_type};
        m_tuser <= head.kind;
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= {6'd0, head.status, 144'd0};
        m_tuser <= KIND_STATUS;
        m_tlast <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mesh_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// mesh_frame_parser_unit: byte-serial receiver for one mesh frame
// Captures the 30-byte little-endian header, forwards nonce, payload and tag
// bytes tagged by kind, and closes each buffer with a status result.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                              Direction  Carries
//  -------   -----------------------------------  ---------  --------------------------
//  s_*       s_tvalid s_tready s_tdata s_tlast    in         one buffer byte, last flag
//  m_*       m_tvalid m_tready m_tdata m_tuser    out        header, byte or status
//            m_tlast                                         result, kind in tuser
//  cfg_*     cfg_valid cfg_ready cfg_index        in         register writes
//            cfg_data
//
// The block takes one byte per cycle while the queue has room. A result
// passes through the queue and the output register to the master side.
// A final byte that also ends in a nonce, payload, tag or header result
// yields two results one after the other and holds up the output while
// both go out; the queue between front end and back end absorbs that.
// Reset is synchronous and active high; it restores the register defaults
// and empties the queue, with no clearing pass. Stalls on the master side
// back up through the queue to s_tready only once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_frame_parser_unit
  import mfp_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4   // queue entries, 2 to 16
)(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Slave stream: tdata = data_byte[7:0]; tlast = end_of_buffer.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,
  input  wire logic                  s_tlast,
  // Master stream: tdata, from bit 0 up = msg_type[7:0], src_id[39:8],
  // dest_id[71:40], msg_id[103:72], ttl[111:104], flags[119:112],
  // decl_len[135:120], byte_out[143:136], status[145:144], zeros[151:146].
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic [2:0]                 m_tuser,   // kind[2:0]
  output logic                       m_tlast,   // last
  // Configuration writes: index 0 expected_version, index 1 max_payload.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [7:0]            cfg_index,
  input  wire logic [15:0]           cfg_data
);

  mfp_entry_t front_entry;
  mfp_entry_t head;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  logic       in_fire;
  logic       cfg_fire;

  // Configuration is always accepted; the front end owns the registers.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // A byte is taken whenever the queue has room, even while the output waits.
  assign s_tready = !full;
  assign in_fire  = s_tvalid && s_tready;

  mfp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .data_byte     (s_tdata),
    .end_of_buffer (s_tlast),
    .cfg_fire      (cfg_fire),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .entry         (front_entry)
  );

  mfp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_entry),
    .pop   (pop),
    .dout  (head),
    .full  (full),
    .empty (empty)
  );

  mfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ----- hdl/mfp_checker.sv -----
// ----------------------------------------------------------------------------
// mfp_checker: port-level assertions for the mesh frame parser
// Watches the top-level ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_checker
  import mfp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic [2:0]            m_tuser,
  input wire logic                  m_tlast
);

  // A stalled result holds its payload until it is transferred.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("master payload changed while stalled");

  // Exactly the status result closes a frame.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
    else $error("tlast does not match status kind");

  // Only header results carry header fields, only status results a status.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_HEADER |-> m_tdata[135:0] == '0)
    else $error("header fields set outside a header result");

  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_STATUS |-> m_tdata[151:144] == '0)
    else $error("status bits set outside a status result");

  // No result can appear in the cycle right after reset.
  a_rst: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind mesh_frame_parser_unit mfp_checker u_mfp_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mesh_frame_parser_unit
// Feeds whole frames byte by byte, good ones and broken ones, under several
// register settings. An in-bench frame parser predicts every header, byte and
// status result, and the monitor checks each transfer on the master side.
// ----------------------------------------------------------------------------

module testbench
  import mfp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 11;
  // Cycles to let pass after the last expected result. This covers the
  // queue and the output register, in case a byte with no result is still
  // on its way through the block.
  localparam int unsigned SETTLE_CYCLES  = 16;
  // Cycles in a row with no transfer on any channel before the run is
  // declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT   = 10;

  // One result as the block presents it on the master side.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  msg_type;
    logic [31:0] src_id;
    logic [31:0] dest_id;
    logic [31:0] msg_id;
    logic [7:0]  ttl;
    logic [7:0]  flags;
    logic [15:0] decl_len;
    logic [7:0]  byte_out;
    logic [1:0]  status;
    logic        last;
  } frame_result_t;

  // One byte of a received buffer, with its end-of-buffer mark.
  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } buffer_byte_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [2:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [7:0]            cfg_index = '0;
  logic [15:0]           cfg_data = '0;

  // Bytes still to be sent, and the results the parser owes us, oldest first.
  buffer_byte_t  frame_bytes[$];
  frame_result_t results_due[$];
  buffer_byte_t  next_byte;

  int unsigned bytes_queued = 0;
  int unsigned bytes_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  // Percentage of cycles in which the sender holds back and the receiver
  // stalls. It drops to zero for one whole phase.
  int unsigned idle_pct = 12;

  // Register copies, as the block holds them after reset.
  logic [7:0]  model_version = EXPECTED_VERSION_RST;
  logic [15:0] model_max_payload = MAX_PAYLOAD_RST;

  // Frame state of the predictor.
  logic [15:0] rx_count = '0;
  logic [7:0]  rx_version = '0;
  logic [7:0]  rx_type = '0;
  logic [31:0] rx_sender = '0;
  logic [31:0] rx_dest = '0;
  logic [31:0] rx_msgid = '0;
  logic [7:0]  rx_ttl = '0;
  logic [7:0]  rx_flags = '0;
  logic [15:0] rx_len = '0;

  mesh_frame_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // data_byte[7:0]
    .s_tlast   (s_tlast),    // end_of_buffer
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // msg_type, src_id, dest_id, msg_id, ttl, flags,
                             // decl_len, byte_out, status, zero padding
    .m_tuser   (m_tuser),    // kind[2:0]
    .m_tlast   (m_tlast),    // last
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Parses one accepted byte the way the block should, and appends every
  // result it causes to results_due. A byte may give a nonce, payload or tag
  // result, or the header once its last byte is in, and the final byte of a
  // buffer adds a status after that.
  function automatic void parse_frame_byte(input logic [7:0] b, input logic eob);
    int unsigned   pos;
    int unsigned   rel;
    int unsigned   plen;
    int unsigned   buf_len;
    frame_result_t r;
    pos = rx_count;
    plen = rx_len;
    r = '0;
    // Once the counter has saturated, bytes are dropped without a trace.
    if (rx_count != COUNT_MAX) begin
      if (pos == OFS_VERSION) begin
        rx_version = b;
      end else if (pos == OFS_TYPE) begin
        rx_type = b;
      end else if (pos < OFS_DEST) begin
        rx_sender[8 * (pos - OFS_SENDER) +: 8] = b;
      end else if (pos < OFS_MSGID) begin
        rx_dest[8 * (pos - OFS_DEST) +: 8] = b;
      end else if (pos < OFS_TTL) begin
        rx_msgid[8 * (pos - OFS_MSGID) +: 8] = b;
      end else if (pos == OFS_TTL) begin
        rx_ttl = b;
      end else if (pos == OFS_FLAGS) begin
        rx_flags = b;
      end else if (pos < OFS_NONCE + NONCE_BYTES) begin
        r.kind = KIND_NONCE;
        r.byte_out = b;
        results_due.push_back(r);
      end else if (pos == OFS_LEN) begin
        rx_len[7:0] = b;
      end else if (pos == OFS_LEN_HI) begin
        rx_len[15:8] = b;
        r.kind = KIND_HEADER;
        r.msg_type = rx_type;
        r.src_id = rx_sender;
        r.dest_id = rx_dest;
        r.msg_id = rx_msgid;
        r.ttl = rx_ttl;
        r.flags = rx_flags;
        r.decl_len = rx_len;
        results_due.push_back(r);
      end else begin
        // Past the header: payload first, then the tag, then nothing.
        rel = pos - HEADER_BYTES;
        if (rel < plen) begin
          r.kind = KIND_PAYLOAD;
          r.byte_out = b;
          results_due.push_back(r);
        end else if (rel < plen + TAG_BYTES) begin
          r.kind = KIND_TAG;
          r.byte_out = b;
          results_due.push_back(r);
        end
      end
      rx_count = rx_count + 16'd1;
    end
    if (eob) begin
      // The length checks are done at 32 bits, so header plus a huge declared
      // payload plus tag never wraps around.
      buf_len = rx_count;
      plen = rx_len;
      r = '0;
      r.kind = KIND_STATUS;
      r.last = 1'b1;
      if (buf_len < HEADER_BYTES + TAG_BYTES) begin
        r.status = ST_SHORT;
      end else if (rx_version != model_version) begin
        r.status = ST_VERSION;
      end else if (rx_len > model_max_payload) begin
        r.status = ST_TOO_LONG;
      end else if (buf_len < HEADER_BYTES + plen + TAG_BYTES) begin
        r.status = ST_SHORT;
      end else begin
        r.status = ST_OK;
      end
      results_due.push_back(r);
      rx_count = '0;
      rx_version = '0;
      rx_type = '0;
      rx_sender = '0;
      rx_dest = '0;
      rx_msgid = '0;
      rx_ttl = '0;
      rx_flags = '0;
      rx_len = '0;
    end
  endfunction

  function automatic string describe(input frame_result_t r);
    return $sformatf({"kind=%0d type=%h snd=%h dst=%h id=%h ttl=%h flg=%h",
                      " len=%h byte=%h st=%0d last=%0d"},
                     r.kind, r.msg_type, r.src_id, r.dest_id, r.msg_id, r.ttl,
                     r.flags, r.decl_len, r.byte_out, r.status, r.last);
  endfunction

  // Queues one buffer of total bytes. The version and the declared payload
  // length sit at their header offsets; every other byte is random. The
  // buffer may end anywhere, inside the header too.
  function automatic void queue_frame(input logic [7:0] version, input logic [15:0] plen,
                                      input int unsigned total);
    buffer_byte_t item;
    for (int unsigned i = 0; i < total; i++) begin
      item.data = 8'($urandom());
      if (i == OFS_VERSION) item.data = version;
      else if (i == OFS_LEN) item.data = plen[7:0];
      else if (i == OFS_LEN_HI) item.data = plen[15:8];
      item.eob = (i == total - 1);
      frame_bytes.push_back(item);
      bytes_queued++;
    end
  endfunction

  // Random frames worth about budget bytes under the current register
  // settings. Most frames are well formed with random content, so that the
  // status comes out ok; the rest carry trailing bytes, a wrong version, an
  // oversized length, an early end, or are plain noise.
  task automatic queue_random_frames(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned cap;
    int unsigned plen;
    int unsigned total;
    logic [7:0]  version;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      pick = $urandom_range(99);
      version = model_version;
      // Mostly small payloads; now and then one up to a few hundred bytes.
      cap = ($urandom_range(15) == 0) ? 300 : 24;
      if (cap > model_max_payload) cap = model_max_payload;
      plen = $urandom_range(cap, 0);
      total = HEADER_BYTES + plen + TAG_BYTES;
      if (pick < 70) begin
        // Well formed, ends right after the tag.
      end else if (pick < 78) begin
        total = total + $urandom_range(8, 1);
      end else if (pick < 84 || (pick < 90 && model_max_payload == COUNT_MAX)) begin
        version = model_version ^ (8'd1 << $urandom_range(7));
      end else if (pick < 90) begin
        plen = model_max_payload + $urandom_range(20, 1);
        if (plen > COUNT_MAX) plen = COUNT_MAX;
        total = HEADER_BYTES + TAG_BYTES + $urandom_range(20);
      end else if (pick < 96) begin
        total = $urandom_range(total - 1, 1);
      end else begin
        version = 8'($urandom());
        plen = $urandom_range(COUNT_MAX);
        total = $urandom_range(80, 1);
      end
      queue_frame(version, 16'(plen), total);
    end
  endtask

  // Waits until every queued byte has been taken and every result it caused
  // has come out, then lets the pipeline settle.
  task automatic wait_drained();
    while (bytes_sent != bytes_queued || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write over the configuration channel. Only called while
  // the block is idle, so the predictor copy can change right away.
  task automatic write_register(input logic [7:0] index, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == REG_EXPECTED_VERSION) model_version = value[7:0];
    else if (index == REG_MAX_PAYLOAD) model_max_payload = value;
  endtask

  // Sender. A byte counts as taken at the edge where tvalid and tready are
  // both high; the predictor runs on it right there. A new byte is loaded
  // whenever the bus is free, unless the sender idles this cycle.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_frame_byte(s_tdata, s_tlast);
        bytes_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (frame_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_byte = frame_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= next_byte.data;
          s_tlast <= next_byte.eob;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Every result transfer is checked against the oldest result
  // due; tready drops at random to stall the block.
  always @(posedge clk) begin
    frame_result_t seen;
    frame_result_t due;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen.kind = m_tuser;
        seen.msg_type = m_tdata[7:0];
        seen.src_id = m_tdata[39:8];
        seen.dest_id = m_tdata[71:40];
        seen.msg_id = m_tdata[103:72];
        seen.ttl = m_tdata[111:104];
        seen.flags = m_tdata[119:112];
        seen.decl_len = m_tdata[135:120];
        seen.byte_out = m_tdata[143:136];
        seen.status = m_tdata[145:144];
        seen.last = m_tlast;
        if (results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%t: result with none due: %s", $realtime, describe(seen));
        end else begin
          due = results_due.pop_front();
          if (seen !== due) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%t: result mismatch", $realtime);
              $display("  expected %s", describe(due));
              $display("  actual   %s", describe(seen));
            end
          end
        end
      end
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog: counts cycles in which no channel makes a transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed frames against the reset values of the registers
    // (version 1, payload limit 200).
    queue_frame(8'hFF, 16'd0, 1);          // buffer of a single byte
    queue_frame(8'd1, 16'd0, 45);          // one byte short of the minimum
    queue_frame(8'd1, 16'd0, 46);          // minimum frame, empty payload
    queue_frame(8'd1, 16'd200, 246);       // payload right at the limit
    queue_frame(8'd1, 16'd201, 60);        // one over the limit
    queue_frame(8'd1, 16'hFFFF, 50);       // largest declared length
    queue_frame(8'd0, 16'd4, 50);          // wrong version
    queue_frame(8'd1, 16'd10, 55);         // shorter than the declared payload
    queue_frame(8'd1, 16'd3, 54);          // five bytes after the tag
    queue_frame(8'd1, 16'd0, 30);          // ends on the last header byte
    queue_frame(8'd1, 16'd0, 16);          // ends on the flags byte
    queue_frame(8'd2, 16'd0, 28);          // ends on the last nonce byte
    queue_random_frames(300);
    wait_drained();

    // Both limits at zero. The upper byte of the version write must be
    // dropped, and a write to a register that does not exist is ignored.
    // The whole phase runs with no idling on either side.
    write_register(REG_EXPECTED_VERSION, 16'hFF00);
    write_register(REG_MAX_PAYLOAD, 16'h0000);
    write_register(8'hFF, 16'($urandom()));
    idle_pct = 0;
    queue_frame(8'd0, 16'd0, 46);
    queue_frame(8'd0, 16'd1, 47);
    queue_random_frames(300);
    wait_drained();
    idle_pct = 12;

    // Both limits at their top. A buffer that declares the largest length
    // passes the limit check; header plus length plus tag overflows 16 bits,
    // so it must still come out short.
    write_register(REG_EXPECTED_VERSION, 16'h00FF);
    write_register(REG_MAX_PAYLOAD, 16'hFFFF);
    queue_random_frames(300);
    queue_frame(8'hFF, 16'hFFFF, 50);
    queue_frame(8'hFF, 16'd2, 48);
    wait_drained();

    // Random middle settings, with another ignored write in between.
    write_register(8'($urandom_range(255, 2)), 16'($urandom()));
    write_register(REG_EXPECTED_VERSION, 16'($urandom()));
    write_register(REG_MAX_PAYLOAD, 16'($urandom_range(300, 1)));
    queue_random_frames(300);
    wait_drained();

    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
